[sv/rbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types, constants and helpers of the retry backoff delay block
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned DelayW  = 32;
  localparam int unsigned BaseW   = 20;
  localparam int unsigned RetryW  = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned PolicyW = 3;
  localparam int unsigned IndexW  = 2;

  // span of a draw is one bit wider than a delay
  localparam int unsigned SpanW = DelayW + 1;

  localparam logic [DelayW-1:0] LfsrTaps  = 32'h8020_0003;
  localparam logic [DelayW-1:0] LfsrReset = 32'h0000_0001;

  localparam logic [3:0] ShiftCapExp  = 4'd10;
  localparam logic [3:0] ShiftCapCont = 4'd8;

  localparam logic [DelayW-1:0] LockLo  = 32'd10;
  localparam logic [DelayW-1:0] LockHi  = 32'd50;
  localparam logic [DelayW-1:0] ValidLo = 32'd50;
  localparam logic [DelayW-1:0] ValidHi = 32'd200;

  localparam logic [PolicyW-1:0] PolicyReset = 3'd0;
  localparam logic [BaseW-1:0]   BaseReset   = 20'd10;
  localparam logic [DelayW-1:0]  MaxReset    = 32'd100000;

  // policy codes
  localparam logic [PolicyW-1:0] PolNone  = 3'd0;
  localparam logic [PolicyW-1:0] PolFixed = 3'd1;
  localparam logic [PolicyW-1:0] PolExp   = 3'd2;
  localparam logic [PolicyW-1:0] PolRand  = 3'd3;
  localparam logic [PolicyW-1:0] PolCont  = 3'd4;

  // abort kinds
  localparam logic [KindW-1:0] KindLock  = 2'd0;
  localparam logic [KindW-1:0] KindValid = 2'd1;

  // register indexes
  localparam logic [IndexW-1:0] RegPolicy = 2'd0;
  localparam logic [IndexW-1:0] RegBase   = 2'd1;
  localparam logic [IndexW-1:0] RegMax    = 2'd2;

  // status from divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DelayW-1:0] lfsr_step(input logic [DelayW-1:0] x);
    logic [DelayW-1:0] y;
    y = x >> 1;
    if (x[0]) begin
      y = y ^ LfsrTaps;
    end
    return y;
  endfunction

endpackage

[sv/rbd_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_divider
// serial restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbd_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rbd_pkg::DelayW-1:0]      dividend,
  input  logic [rbd_pkg::SpanW-1:0]       divisor,
  output logic [rbd_pkg::DelayW-1:0]      remainder,
  output rbd_pkg::div_stat_t              stat
);

  localparam int unsigned CntW = $clog2(rbd_pkg::DelayW + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } div_state_t;

  div_state_t                  state;
  logic [rbd_pkg::SpanW-1:0]   rem;
  logic [rbd_pkg::SpanW-1:0]   dsr;
  logic [rbd_pkg::DelayW-1:0]  dq;
  logic [CntW-1:0]             cnt;
  logic                        done;

  logic [rbd_pkg::SpanW:0]     rem_sh;
  logic                        fits;

  always_comb begin
    rem_sh = {rem, dq[rbd_pkg::DelayW-1]};
    fits   = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            rem   <= '0;
            dsr   <= divisor;
            dq    <= dividend;
            cnt   <= CntW'(rbd_pkg::DelayW);
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (fits) begin
            rem <= rbd_pkg::SpanW'(rem_sh - {1'b0, dsr});
          end else begin
            rem <= rem_sh[rbd_pkg::SpanW-1:0];
          end
          dq  <= dq << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // remainder is below the divisor, so it fits a delay word
  assign remainder = rem[rbd_pkg::DelayW-1:0];
  assign stat.busy = (state == S_RUN);
  assign stat.done = done;

endmodule

[sv/retry_backoff_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retry_backoff_delay
// backoff delay selection for aborted transactions
// ----------------------------------------------------------------------------
// Each request on the slave stream carries an abort kind and a retry count
// and yields one delay in microseconds on the master stream, chosen by the
// policy register: none, fixed, exponential, randomized exponential or
// contention aware. A 32-bit Galois LFSR advances once per request. A request
// that needs no random draw passes from S_CALC straight to S_OUT; one that
// draws also waits in S_DIV for the serial remainder unit, which retires
// one bit of r mod span per cycle over 32 steps. The block takes one request
// at a time; s_tready is high only while the sequencer is idle, and a result
// waiting in the output register does not hold off the next request.
// Configuration writes are always taken and are meant for idle periods.
// ----------------------------------------------------------------------------
module retry_backoff_delay (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // abort_kind[1:0], retry_number[17:2]
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rbd_pkg::DelayW-1:0]     m_tdata,   // delay_us[31:0]
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbd_pkg::IndexW-1:0]     cfg_index,
  input  logic [rbd_pkg::DelayW-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_OUT
  } seq_state_t;

  seq_state_t                     state;

  // configuration registers
  logic [rbd_pkg::PolicyW-1:0]    policy_mode;
  logic [rbd_pkg::BaseW-1:0]      base_delay;
  logic [rbd_pkg::DelayW-1:0]     max_delay;

  // request state
  logic [rbd_pkg::DelayW-1:0]     random_register;
  logic [rbd_pkg::KindW-1:0]      kind;
  logic [rbd_pkg::RetryW-1:0]     retry;
  logic [rbd_pkg::DelayW-1:0]     lo;
  logic [rbd_pkg::DelayW-1:0]     result;

  // setup arithmetic
  logic [3:0]                     shift_cap;
  logic [3:0]                     sh;
  logic [29:0]                    shifted;
  logic [rbd_pkg::DelayW-1:0]     cap_val;
  logic [rbd_pkg::DelayW-1:0]     lo_next;
  logic [rbd_pkg::DelayW-1:0]     hi_next;
  logic                           draw;
  logic [rbd_pkg::SpanW-1:0]      span;

  // remainder unit
  logic                           div_start;
  logic [rbd_pkg::DelayW-1:0]     div_rem;
  rbd_pkg::div_stat_t             div_stat;

  logic                           out_free;
  logic                           s_accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    // contention aware caps the shift lower than the exponential policies
    shift_cap = (policy_mode == rbd_pkg::PolCont) ? rbd_pkg::ShiftCapCont
                                                  : rbd_pkg::ShiftCapExp;
    sh        = (retry < {12'd0, shift_cap}) ? retry[3:0] : shift_cap;
    // a 20-bit base shifted by at most 10 never saturates
    shifted   = {10'd0, base_delay} << sh;
    cap_val   = ({2'b00, shifted} < max_delay) ? {2'b00, shifted} : max_delay;

    draw    = 1'b0;
    lo_next = '0;
    hi_next = '0;
    case (policy_mode)
      rbd_pkg::PolFixed: hi_next = {12'd0, base_delay};
      rbd_pkg::PolExp:   hi_next = cap_val;
      rbd_pkg::PolRand: begin
        draw    = 1'b1;
        lo_next = {12'd0, base_delay};
        hi_next = cap_val;
      end
      rbd_pkg::PolCont: begin
        draw = 1'b1;
        case (kind)
          rbd_pkg::KindLock: begin
            lo_next = rbd_pkg::LockLo;
            hi_next = rbd_pkg::LockHi;
          end
          rbd_pkg::KindValid: begin
            lo_next = rbd_pkg::ValidLo;
            hi_next = rbd_pkg::ValidHi;
          end
          default: begin
            lo_next = {12'd0, base_delay};
            hi_next = cap_val;
          end
        endcase
      end
      default: hi_next = '0;
    endcase

    // empty range answers with the cap itself
    if (hi_next < lo_next) begin
      draw = 1'b0;
    end
    span      = {1'b0, hi_next} - {1'b0, lo_next} + rbd_pkg::SpanW'(1);
    div_start = (state == S_CALC) && draw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      policy_mode     <= rbd_pkg::PolicyReset;
      base_delay      <= rbd_pkg::BaseReset;
      max_delay       <= rbd_pkg::MaxReset;
      random_register <= rbd_pkg::LfsrReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rbd_pkg::RegPolicy: policy_mode <= cfg_data[rbd_pkg::PolicyW-1:0];
          rbd_pkg::RegBase:   base_delay  <= cfg_data[rbd_pkg::BaseW-1:0];
          rbd_pkg::RegMax:    max_delay   <= cfg_data;
          default: ;
        endcase
      end

      // in the output state a taken result is replaced by the next one below
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_accept) begin
            // lfsr steps once per request whatever the policy
            random_register <= rbd_pkg::lfsr_step(random_register);
            kind            <= s_tdata[1:0];
            retry           <= s_tdata[17:2];
            state           <= S_CALC;
          end
        end
        S_CALC: begin
          lo     <= lo_next;
          result <= hi_next;
          state  <= draw ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_stat.done) begin
            result <= lo + div_rem;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tdata  <= result;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rbd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (random_register),
    .divisor   (span),
    .remainder (div_rem),
    .stat      (div_stat)
  );

endmodule

[test/retry_backoff_delay_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retry_backoff_delay_test
// self-checking bench for the retry backoff delay block
// ----------------------------------------------------------------------------
// Sends requests on the slave stream and writes the policy, base and cap
// registers between phases, while the bench's own model of the block works
// out the delay of each request: its own copy of the LFSR and registers,
// advanced once per accepted request. Each delay on the master stream is
// compared with the oldest prediction. Both streams idle at random. A short
// directed part covers every policy and the corner cases; random phases with
// fresh register settings follow.
// ----------------------------------------------------------------------------
module retry_backoff_delay_test;

  // codes the package leaves unnamed
  localparam logic [rbd_pkg::KindW-1:0]   KindOther   = 2'd2;
  localparam logic [rbd_pkg::KindW-1:0]   KindSpare   = 2'd3;
  localparam logic [rbd_pkg::PolicyW-1:0] PolUnusedLo = 3'd5;
  localparam logic [rbd_pkg::PolicyW-1:0] PolUnusedHi = 3'd7;
  localparam logic [rbd_pkg::IndexW-1:0]  RegUnused   = 2'd3;

  localparam logic [rbd_pkg::RetryW-1:0]  RetryTop    = 16'hFFFF;
  localparam logic [rbd_pkg::DelayW-1:0]  DelayTop    = 32'hFFFF_FFFF;
  localparam logic [rbd_pkg::BaseW-1:0]   BaseTop     = 20'hF_FFFF;

  localparam int ReportLimit  = 10;
  localparam int TailCycles   = 60;
  localparam int RandomPhases = 9;
  localparam int PhaseItems   = 50;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [23:0]                  s_tdata;    // abort_kind[1:0], retry_number[17:2]
  logic                         m_tvalid;
  logic                         m_tready;
  logic [rbd_pkg::DelayW-1:0]   m_tdata;    // delay_us[31:0]
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [rbd_pkg::IndexW-1:0]   cfg_index;
  logic [rbd_pkg::DelayW-1:0]   cfg_data;

  // bench copy of the block state
  logic [rbd_pkg::PolicyW-1:0]  policy_q;
  logic [rbd_pkg::BaseW-1:0]    base_q;
  logic [rbd_pkg::DelayW-1:0]   cap_q;
  logic [rbd_pkg::DelayW-1:0]   lfsr_q;

  // predicted delays, oldest first
  logic [rbd_pkg::DelayW-1:0]   expected_delays[$];

  int  fault_count;
  bit  gaps_on;
  bit  stall_on;
  int  stall_left;

  retry_backoff_delay u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle length: mostly short, now and then a long one
  function automatic int pause_length();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  // base shifted by the capped retry count, saturated, then limited by the cap
  function automatic logic [rbd_pkg::DelayW-1:0] capped_backoff(
      input logic [rbd_pkg::RetryW-1:0] retry,
      input logic [3:0] shift_cap);
    int                         sh;
    logic [63:0]                prod;
    logic [rbd_pkg::DelayW-1:0] v;
    sh   = (retry < shift_cap) ? int'(retry) : int'(shift_cap);
    prod = {44'd0, base_q} << sh;
    v    = (prod > {32'd0, DelayTop}) ? DelayTop : prod[rbd_pkg::DelayW-1:0];
    return (v < cap_q) ? v : cap_q;
  endfunction

  // uniform pick in [lo, hi] from the lfsr value; an empty range gives hi
  function automatic logic [rbd_pkg::DelayW-1:0] range_pick(
      input logic [rbd_pkg::DelayW-1:0] lo,
      input logic [rbd_pkg::DelayW-1:0] hi,
      input logic [rbd_pkg::DelayW-1:0] r);
    logic [63:0] span;
    logic [63:0] sum;
    if (hi < lo) begin
      return hi;
    end
    span = {32'd0, hi} - {32'd0, lo} + 64'd1;
    sum  = {32'd0, lo} + ({32'd0, r} % span);
    return sum[rbd_pkg::DelayW-1:0];
  endfunction

  // advance the lfsr once and work out the delay of one request
  function automatic logic [rbd_pkg::DelayW-1:0] next_delay(
      input logic [rbd_pkg::KindW-1:0] kind,
      input logic [rbd_pkg::RetryW-1:0] retry);
    logic [rbd_pkg::DelayW-1:0] shifted;
    logic [rbd_pkg::DelayW-1:0] base_wide;
    shifted = {1'b0, lfsr_q[rbd_pkg::DelayW-1:1]};
    if (lfsr_q[0]) begin
      shifted = shifted ^ rbd_pkg::LfsrTaps;
    end
    lfsr_q    = shifted;
    base_wide = {12'd0, base_q};
    case (policy_q)
      rbd_pkg::PolFixed: return base_wide;
      rbd_pkg::PolExp:   return capped_backoff(retry, rbd_pkg::ShiftCapExp);
      rbd_pkg::PolRand:
        return range_pick(base_wide, capped_backoff(retry, rbd_pkg::ShiftCapExp), lfsr_q);
      rbd_pkg::PolCont: begin
        if (kind == rbd_pkg::KindLock) begin
          return range_pick(rbd_pkg::LockLo, rbd_pkg::LockHi, lfsr_q);
        end else if (kind == rbd_pkg::KindValid) begin
          return range_pick(rbd_pkg::ValidLo, rbd_pkg::ValidHi, lfsr_q);
        end
        // any other reason, spare kind included
        return range_pick(base_wide, capped_backoff(retry, rbd_pkg::ShiftCapCont), lfsr_q);
      end
      default:  return '0;
    endcase
  endfunction

  task automatic report_fault(input string what, input logic [rbd_pkg::DelayW-1:0] want,
                              input logic [rbd_pkg::DelayW-1:0] got);
    if (fault_count < ReportLimit) begin
      $display("%0t ns: %s: expected %h, got %h", $realtime, what, want, got);
    end
    fault_count++;
  endtask

  // one request on the slave stream; valid stays high when no gap follows
  task automatic send_request(input logic [rbd_pkg::KindW-1:0] kind,
                              input logic [rbd_pkg::RetryW-1:0] retry);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) >= 55) begin
      gap = pause_length();
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, retry, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_delays.push_back(next_delay(kind, retry));
    @(negedge clk);
  endtask

  // one register write; the bench copy follows at the accepting edge
  task automatic write_register(input logic [rbd_pkg::IndexW-1:0] idx,
                                input logic [rbd_pkg::DelayW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rbd_pkg::RegPolicy: policy_q = value[rbd_pkg::PolicyW-1:0];
      rbd_pkg::RegBase:   base_q   = value[rbd_pkg::BaseW-1:0];
      rbd_pkg::RegMax:    cap_q    = value;
      default:   ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop requesting and wait until every predicted delay has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_delays.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // policy none straight out of reset, lfsr still stepping
  task automatic test_reset_state();
    send_request(rbd_pkg::KindLock, '0);
    send_request(KindOther, RetryTop);
  endtask

  // fixed policy at base extremes, a write to the spare index, unused codes
  task automatic test_fixed_and_unused();
    drain_results();
    write_register(RegUnused, $urandom());
    write_register(rbd_pkg::RegPolicy, {29'h1FFF_FFFF, rbd_pkg::PolFixed});
    write_register(rbd_pkg::RegBase, {12'hFFF, BaseTop});
    send_request(rbd_pkg::KindValid, 16'd5);
    drain_results();
    write_register(rbd_pkg::RegBase, '0);
    send_request(KindSpare, RetryTop);
    drain_results();
    write_register(rbd_pkg::RegPolicy, {29'd0, PolUnusedLo});
    send_request(rbd_pkg::KindLock, 16'd1);
    drain_results();
    write_register(rbd_pkg::RegPolicy, {29'h1FFF_FFFF, PolUnusedHi});
    send_request(KindOther, 16'd2);
  endtask

  // shift below, at and above its cap, a zero cap, a small base
  task automatic test_exponential();
    drain_results();
    write_register(rbd_pkg::RegPolicy, {29'd0, rbd_pkg::PolExp});
    write_register(rbd_pkg::RegBase, {12'd0, BaseTop});
    write_register(rbd_pkg::RegMax, DelayTop);
    send_request(rbd_pkg::KindLock, 16'd0);
    send_request(rbd_pkg::KindValid, 16'd10);
    send_request(KindOther, 16'd11);
    send_request(KindSpare, RetryTop);
    drain_results();
    write_register(rbd_pkg::RegMax, '0);
    send_request(KindOther, 16'd3);
    drain_results();
    write_register(rbd_pkg::RegBase, 32'd1);
    write_register(rbd_pkg::RegMax, rbd_pkg::MaxReset);
    send_request(rbd_pkg::KindLock, 16'd9);
  endtask

  // wide span, cap under the base (empty range), single-value range
  task automatic test_randomized();
    drain_results();
    write_register(rbd_pkg::RegPolicy, {29'd0, rbd_pkg::PolRand});
    write_register(rbd_pkg::RegBase, {12'd0, BaseTop});
    write_register(rbd_pkg::RegMax, DelayTop);
    send_request(KindOther, 16'd10);
    drain_results();
    write_register(rbd_pkg::RegMax, 32'd5);
    send_request(rbd_pkg::KindLock, 16'd2);
    drain_results();
    write_register(rbd_pkg::RegBase, '0);
    write_register(rbd_pkg::RegMax, '0);
    send_request(rbd_pkg::KindValid, RetryTop);
    drain_results();
    write_register(rbd_pkg::RegBase, 32'd3);
    write_register(rbd_pkg::RegMax, DelayTop);
    send_request(KindOther, RetryTop);
  endtask

  // fixed ranges for lock and validation, shift capped at 8 for the rest
  task automatic test_contention();
    drain_results();
    write_register(rbd_pkg::RegPolicy, {29'd0, rbd_pkg::PolCont});
    write_register(rbd_pkg::RegBase, 32'd7);
    write_register(rbd_pkg::RegMax, DelayTop);
    send_request(rbd_pkg::KindLock, 16'd0);
    send_request(rbd_pkg::KindValid, RetryTop);
    send_request(KindOther, 16'd8);
    send_request(KindSpare, 16'd9);
    drain_results();
    write_register(rbd_pkg::RegBase, {12'd0, BaseTop});
    send_request(KindOther, RetryTop);
    drain_results();
    write_register(rbd_pkg::RegMax, '0);
    send_request(KindOther, 16'd4);
  endtask

  // phases of random requests, each under a fresh register setting
  task automatic test_random_traffic();
    int                          phase;
    int                          n;
    logic [rbd_pkg::PolicyW-1:0] pol;
    logic [rbd_pkg::DelayW-1:0]  word;
    logic [rbd_pkg::KindW-1:0]   kind;
    logic [rbd_pkg::RetryW-1:0]  retry;
    for (phase = 0; phase < RandomPhases; phase++) begin
      drain_results();
      gaps_on  = (phase % 3) != 0;
      stall_on = (phase % 4) != 1;
      case ($urandom_range(0, 5))
        0:       pol = rbd_pkg::PolicyW'($urandom_range(0, 7));
        1:       pol = rbd_pkg::PolExp;
        2, 3:    pol = rbd_pkg::PolRand;
        default: pol = rbd_pkg::PolCont;
      endcase
      word = $urandom();
      word[rbd_pkg::PolicyW-1:0] = pol;
      write_register(rbd_pkg::RegPolicy, word);
      // upper bits of the base word are random and must be dropped
      word = $urandom();
      case ($urandom_range(0, 3))
        0:       word[rbd_pkg::BaseW-1:0] = rbd_pkg::BaseW'($urandom_range(0, 40));
        1:       word[rbd_pkg::BaseW-1:0] = BaseTop;
        2:       word[rbd_pkg::BaseW-1:0] = rbd_pkg::BaseW'($urandom_range(0, 4000));
        default: ;
      endcase
      write_register(rbd_pkg::RegBase, word);
      case ($urandom_range(0, 4))
        0:       word = '0;
        1:       word = DelayTop;
        2:       word = $urandom();
        3:       word = $urandom_range(0, 5000);
        default: word = $urandom_range(0, 1000000);
      endcase
      write_register(rbd_pkg::RegMax, word);
      for (n = 0; n < PhaseItems; n++) begin
        kind = ($urandom_range(0, 9) == 0) ? KindSpare
                                           : rbd_pkg::KindW'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) begin
          retry = rbd_pkg::RetryW'($urandom());
        end else begin
          retry = rbd_pkg::RetryW'($urandom_range(0, 14));
        end
        send_request(kind, retry);
      end
    end
    drain_results();
  endtask

  // result checker: each accepted delay against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_delays.size() == 0) begin
        report_fault("delay with no request pending", '0, m_tdata);
      end else begin
        if (m_tdata !== expected_delays[0]) begin
          report_fault("delay mismatch", expected_delays[0], m_tdata);
        end
        void'(expected_delays.pop_front());
      end
    end
  end

  // result back-pressure, changed at the falling edge only
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        stall_left = pause_length() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    #12_000_000;
    $display("retry_backoff_delay_test: errors");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    fault_count = 0;
    gaps_on     = 1'b0;
    stall_on    = 1'b0;
    // bench copy starts from the reset state of the block
    policy_q    = rbd_pkg::PolicyReset;
    base_q      = rbd_pkg::BaseReset;
    cap_q       = rbd_pkg::MaxReset;
    lfsr_q      = rbd_pkg::LfsrReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_fixed_and_unused();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_exponential();
    test_randomized();
    test_contention();
    test_random_traffic();

    // quiet tail so a stray extra delay is still caught
    repeat (TailCycles) @(posedge clk);
    if (expected_delays.size() != 0) begin
      report_fault("predicted delay never came", expected_delays[0], '0);
    end
    if (fault_count == 0) begin
      $display("retry_backoff_delay_test: clean");
    end else begin
      $display("retry_backoff_delay_test: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rbd_pkg.sv
sv/rbd_divider.sv
sv/retry_backoff_delay.sv
test/retry_backoff_delay_test.sv
